>>> src/unsorted_set_table_top_assert.svh
// Assertion macros shared by the unsorted set table RTL.
// Needs a clock and an active-high reset name at the place of use.
`ifndef UNSORTED_SET_TABLE_TOP_ASSERT_SVH
`define UNSORTED_SET_TABLE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define UST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("unsorted_set_table assertion failed");
// condition must never be true outside reset
`define UST_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("unsorted_set_table forbidden condition seen");
`else
`define UST_ASSERT(lbl, clk, rst, prop)
`define UST_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> src/ust_pkg.sv
// Shared constants and types for the unsorted set table.
// No dependencies.
`default_nettype none
package ust_pkg;
   localparam int DEPTH    = 64;
   localparam int KEY_BITS = 64;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 64;
   localparam int POS_W    = 6;
   localparam int ENT_W    = 7;
   localparam int CAP_W    = 7;
   localparam int REQ_W    = 72;
   localparam int RSP_W    = 16;

   localparam logic [FUNC_W-1:0] OP_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] OP_FIND   = 2'd2;
   localparam logic [FUNC_W-1:0] OP_COUNT  = 2'd3;

   typedef struct packed {
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      logic [KEY_BITS-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
      logic [ENT_W-1:0] entries;
      logic             full_reject;
   } result_type;
endpackage
`default_nettype wire

>>> src/ust_store.sv
// Key store: single-port-write, single-port-read RAM, registered read.
// Depends on ust_pkg.
`default_nettype none
module ust_store (
   input  wire                          clock,
   input  wire ust_pkg::mem_req_type    mem_req,
   output logic [ust_pkg::KEY_BITS-1:0] rd_data
);
   logic [ust_pkg::KEY_BITS-1:0] mem [ust_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data <= mem[mem_req.rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> src/ust_ctrl.sv
// Sequencer: linear scan over the key store, then add/remove write-back.
// Depends on ust_pkg and unsorted_set_table_top_assert.svh.
`default_nettype none
`include "unsorted_set_table_top_assert.svh"
module ust_ctrl (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire  [ust_pkg::FUNC_W-1:0]      func,
   input  wire  [ust_pkg::KEY_BITS-1:0]    key,
   input  wire  [ust_pkg::CNT_W-1:0]       limit,
   output logic                            idle,
   output ust_pkg::mem_req_type            mem_req,
   input  wire  [ust_pkg::KEY_BITS-1:0]    rd_data,
   output logic                            res_valid,
   output ust_pkg::result_type             res,
   input  wire                             res_ready
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_MOVE   = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;

   logic [2:0]                   state_ff, state_in;
   logic [ust_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [ust_pkg::FUNC_W-1:0]   op_ff, op_in;
   logic [ust_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [ust_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [ust_pkg::IDX_W-1:0]    slot_ff, slot_in;
   logic                         hit_ff, hit_in;
   logic                         rej_ff, rej_in;
   logic [ust_pkg::CNT_W-1:0]    idx_next;
   logic [ust_pkg::CNT_W-1:0]    count_dec;

   assign idx_next  = ust_pkg::CNT_W'(idx_ff) + 1'b1;
   assign count_dec = count_ff - 1'b1;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      idx_in   = idx_ff;
      slot_in  = slot_ff;
      hit_in   = hit_ff;
      rej_in   = rej_ff;
      mem_req  = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = func;
               key_in  = key;
               idx_in  = '0;
               slot_in = '0;
               hit_in  = 1'b0;
               rej_in  = 1'b0;
               if (func == ust_pkg::OP_COUNT) begin
                  state_in = S_FINISH;
               end else if (count_ff == '0) begin
                  // empty set: straight to the miss handling
                  state_in = S_FINISH;
                  if (func == ust_pkg::OP_ADD) begin
                     if (limit != '0) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = '0;
                        mem_req.wr_data = key;
                        count_in        = count_ff + 1'b1;
                     end else begin
                        rej_in = 1'b1;
                     end
                  end
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
                  state_in        = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_data == key_ff) begin
               hit_in  = 1'b1;
               slot_in = idx_ff;
               if (op_ff == ust_pkg::OP_REMOVE) begin
                  // fetch the last live key to fill the hole
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = count_dec[ust_pkg::IDX_W-1:0];
                  count_in        = count_dec;
                  state_in        = S_MOVE;
               end else begin
                  state_in = S_FINISH;
               end
            end else if (idx_next < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_next[ust_pkg::IDX_W-1:0];
               idx_in          = idx_next[ust_pkg::IDX_W-1:0];
            end else begin
               state_in = S_FINISH;
               if (op_ff == ust_pkg::OP_ADD) begin
                  if (count_ff < limit) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = count_ff[ust_pkg::IDX_W-1:0];
                     mem_req.wr_data = key_ff;
                     slot_in         = count_ff[ust_pkg::IDX_W-1:0];
                     count_in        = count_ff + 1'b1;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
            end
         end
         S_MOVE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = slot_ff;
            mem_req.wr_data = rd_data;
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      hit_ff  <= hit_in;
      rej_ff  <= rej_in;
   end

   assign idle                = (state_ff == S_IDLE);
   assign res_valid           = (state_ff == S_FINISH);
   assign res.found           = hit_ff;
   assign res.position        = ust_pkg::POS_W'(slot_ff);
   assign res.entries         = ust_pkg::ENT_W'(count_ff);
   assign res.full_reject     = rej_ff;

   `UST_NEVER(a_count_bound, clock, reset, count_ff > ust_pkg::CNT_W'(ust_pkg::DEPTH))
   `UST_ASSERT(a_start_leaves_idle, clock, reset, (idle && start) |=> !idle)
   `UST_NEVER(a_reject_with_hit, clock, reset, res_valid && hit_ff && rej_ff)
   `UST_ASSERT(a_move_after_hit, clock, reset, (state_ff == S_MOVE) |-> hit_ff)
endmodule
`default_nettype wire

>>> src/unsorted_set_table_top.sv
// Unsorted set table top level: stream ports, capacity register, result register.
// Depends on ust_pkg, ust_store, ust_ctrl and unsorted_set_table_top_assert.svh.
//
// Usage:
//   Each request beat carries an operation (add, remove, find, count) and a
//   64-bit key. Every request gives exactly one response beat with found,
//   position, entry count and a full-reject flag.
//   Keys live unsorted in a 64-entry RAM (registered read) and are found by
//   a linear scan from slot 0, one slot per cycle.
//   A count, or a request on an empty set, goes straight to the result;
//   otherwise the scan runs first, and a remove that hits adds a move step
//   that fills the hole with the last live key. The slowest request is a
//   remove that hits the last slot of a full table. One request is worked
//   at a time.
//   The response sits in an output register; the next request is taken as
//   soon as the sequencer is idle, even while that response is stalled.
//   A stalled rsp channel holds the finished result and, once the next
//   result is ready, the sequencer waits for the register to drain.
//   Reset (synchronous, active high) empties the set and sets capacity
//   to 64; RAM contents are not cleared, slots above the count are unread.
//   csr_wr_en writes the capacity (limit is min(capacity, 64)); write it
//   only while no request is outstanding.
`default_nettype none
`include "unsorted_set_table_top_assert.svh"
module unsorted_set_table_top (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [ust_pkg::REQ_W-1:0]    req_tdata,  // func[1:0], key[65:2], zero pad
   // response channel
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [ust_pkg::RSP_W-1:0]    rsp_tdata,  // found[0], position[6:1],
                                                    // entries[13:7], full_reject[14], pad
   // capacity register write
   input  wire                          csr_wr_en,
   input  wire  [ust_pkg::CAP_W-1:0]    csr_wr_data
);
   logic [ust_pkg::CAP_W-1:0]    cap_ff;
   logic [ust_pkg::CNT_W-1:0]    limit;
   logic                         idle;
   logic                         req_fire;
   ust_pkg::mem_req_type         mem_req;
   logic [ust_pkg::KEY_BITS-1:0] rd_data;
   logic                         res_valid;
   logic                         res_ready;
   ust_pkg::result_type          res;
   logic                         rsp_valid_ff, rsp_valid_in;
   ust_pkg::result_type          rsp_data_ff;
   logic [ust_pkg::FUNC_W-1:0]   req_func;
   logic [ust_pkg::KEY_BITS-1:0] req_key;

   // field unpack; key bits above KEY_BITS are dropped
   assign req_func = req_tdata[ust_pkg::FUNC_W-1:0];
   assign req_key  = req_tdata[ust_pkg::FUNC_W +: ust_pkg::KEY_BITS];

   assign req_tready = idle;
   assign req_fire   = req_tvalid && req_tready;

   // capacity saturates at the RAM depth
   always_comb begin
      if (cap_ff > ust_pkg::CAP_W'(ust_pkg::DEPTH)) begin
         limit = ust_pkg::CNT_W'(ust_pkg::DEPTH);
      end else begin
         limit = ust_pkg::CNT_W'(cap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= ust_pkg::CAP_W'(64);
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   ust_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ust_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .func      (req_func),
      .key       (req_key),
      .limit     (limit),
      .idle      (idle),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // output register: free when empty or draining this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.full_reject, rsp_data_ff.entries,
                        rsp_data_ff.position, rsp_data_ff.found};

   `UST_ASSERT(a_res_loads_rsp, clock, reset, (res_valid && res_ready) |=> rsp_tvalid)
   `UST_NEVER(a_accept_while_busy, clock, reset, req_fire && res_valid)
endmodule
`default_nettype wire

>>> verif/ust_set_checker.sv
// Monitor and scoreboard for the unsorted set table: mirrors the key set and
// checks every response beat against it. Depends on ust_pkg.
module ust_set_checker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   input  wire                       req_tready,
   input  wire  [ust_pkg::REQ_W-1:0] req_tdata,
   input  wire                       rsp_tvalid,
   input  wire                       rsp_tready,
   input  wire  [ust_pkg::RSP_W-1:0] rsp_tdata,
   input  wire                       csr_wr_en,
   input  wire  [ust_pkg::CAP_W-1:0] csr_wr_data,
   output int                        errors,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [ust_pkg::KEY_BITS-1:0] mirror_keys [ust_pkg::DEPTH];
   logic [ust_pkg::CNT_W-1:0]    mirror_count;
   logic [ust_pkg::CAP_W-1:0]    mirror_capacity;
   ust_pkg::result_type          pending_results [$];
   int                           bad_beats = 0;

   // Applies one operation to the mirrored set, returns the response it owes.
   function automatic ust_pkg::result_type set_table_apply(
      logic [ust_pkg::FUNC_W-1:0]   func,
      logic [ust_pkg::KEY_BITS-1:0] key);
      ust_pkg::result_type r;
      int                  limit;
      int                  slot;
      bit                  hit;
      r     = '0;
      limit = (mirror_capacity < ust_pkg::DEPTH) ? int'(mirror_capacity) : ust_pkg::DEPTH;
      slot  = 0;
      hit   = 1'b0;
      if (func != ust_pkg::OP_COUNT) begin
         for (int i = 0; i < int'(mirror_count); i++) begin
            if (!hit && mirror_keys[i] == key) begin
               hit  = 1'b1;
               slot = i;
            end
         end
      end
      case (func)
         ust_pkg::OP_ADD: begin
            if (!hit) begin
               if (int'(mirror_count) < limit) begin
                  slot = int'(mirror_count);
                  mirror_keys[slot] = key;
                  mirror_count++;
               end else begin
                  r.full_reject = 1'b1;
               end
            end
         end
         ust_pkg::OP_REMOVE: begin
            if (hit) begin
               mirror_count--;
               mirror_keys[slot] = mirror_keys[mirror_count];
            end
         end
         default: ;
      endcase
      r.found    = hit;
      r.position = slot[ust_pkg::POS_W-1:0];
      r.entries  = ust_pkg::ENT_W'(mirror_count);
      return r;
   endfunction

   task automatic flag_beat(string msg);
      bad_beats++;
      if (bad_beats <= 10) $display("[%0t] rsp mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      ust_pkg::result_type got;
      ust_pkg::result_type want;
      if (reset) begin
         mirror_count    = '0;
         mirror_capacity = ust_pkg::CAP_W'(ust_pkg::DEPTH);
         pending_results.delete();
      end else begin
         if (csr_wr_en) mirror_capacity = csr_wr_data;
         if (req_tvalid && req_tready)
            pending_results.push_back(set_table_apply(
               req_tdata[ust_pkg::FUNC_W-1:0],
               req_tdata[ust_pkg::FUNC_W +: ust_pkg::KEY_BITS]));
         if (rsp_tvalid && rsp_tready) begin
            got.found       = rsp_tdata[0];
            got.position    = rsp_tdata[6:1];
            got.entries     = rsp_tdata[13:7];
            got.full_reject = rsp_tdata[14];
            if (pending_results.size() == 0) begin
               flag_beat($sformatf("unexpected beat found=%b pos=%0d ent=%0d rej=%b",
                                   got.found, got.position, got.entries, got.full_reject));
            end else begin
               want = pending_results.pop_front();
               if (got !== want)
                  flag_beat($sformatf({"exp found=%b pos=%0d ent=%0d rej=%b, ",
                                       "got found=%b pos=%0d ent=%0d rej=%b"},
                                      want.found, want.position, want.entries,
                                      want.full_reject, got.found, got.position,
                                      got.entries, got.full_reject));
            end
         end
      end
      errors      <= bad_beats;
      outstanding <= pending_results.size();
   end
endmodule

>>> verif/unsorted_set_table_top_tb.sv
// Testbench top for the unsorted set table: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on ust_pkg, ust_set_checker.
module unsorted_set_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAD_W       = ust_pkg::REQ_W - ust_pkg::FUNC_W - ust_pkg::KEY_W;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int POOL_N      = 96;

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_tvalid  = 1'b0;
   wire                         req_tready;
   logic [ust_pkg::REQ_W-1:0]   req_tdata   = '0;   // func[1:0], key[65:2], zero pad
   wire                         rsp_tvalid;
   logic                        rsp_tready  = 1'b0;
   wire  [ust_pkg::RSP_W-1:0]   rsp_tdata;          // found[0], position[6:1],
                                                    // entries[13:7], full_reject[14]
   logic                        csr_wr_en   = 1'b0;
   logic [ust_pkg::CAP_W-1:0]   csr_wr_data = '0;

   int                          errors;
   int                          outstanding;
   int                          cycles = 0;
   int unsigned                 send_idle_pct  = 0;  // chance per beat slot of a gap
   int unsigned                 recv_stall_pct = 0;  // chance per cycle of tready low
   logic [63:0]                 key_pool [POOL_N];

   unsorted_set_table_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ust_set_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response back-pressure, redrawn every cycle so stalls land on any
   // point of the scan, including while the next search is already running.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // One request beat. Optional idle cycles first; tvalid stays high across
   // back-to-back beats, only tdata changes.
   task automatic send_beat(logic [ust_pkg::FUNC_W-1:0] func, logic [63:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {{PAD_W{1'b0}}, key, func};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and wait until every response has been taken. The first
   // edge lets the checker count a beat accepted at the current edge.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Capacity is only written with the table idle.
   task automatic set_capacity(logic [ust_pkg::CAP_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic: mostly keys from the shared pool so adds collide and
   // removes/finds hit; one beat in ten uses a fresh key (almost always a miss).
   task automatic run_phase(int cap, int pool_n, int add_pct, int rm_pct,
                            int send_pct, int recv_pct, int n);
      logic [ust_pkg::FUNC_W-1:0] func;
      logic [63:0]                key;
      int                         roll;
      set_capacity(cap[ust_pkg::CAP_W-1:0]);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < add_pct)               func = ust_pkg::OP_ADD;
         else if (roll < add_pct + rm_pct) func = ust_pkg::OP_REMOVE;
         else if (roll < 92)               func = ust_pkg::OP_FIND;
         else                              func = ust_pkg::OP_COUNT;
         if ($urandom_range(9) == 0) key = {$urandom, $urandom};
         else                        key = key_pool[$urandom_range(pool_n - 1)];
         send_beat(func, key);
         // now and then let the table run dry mid-phase
         if ($urandom_range(49) == 0) drain();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Pool: both extremes, random words, and near-twins one bit apart from
      // earlier entries so the compare must look at every key bit.
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_N; i++) begin
         if (i >= 8 && $urandom_range(3) == 0)
            key_pool[i] = key_pool[$urandom_range(i - 1)] ^ (64'd1 << $urandom_range(63));
         else
            key_pool[i] = {$urandom, $urandom};
      end

      // Directed, capacity at its reset value.
      send_beat(ust_pkg::OP_COUNT,  '0);                     // empty set
      send_beat(ust_pkg::OP_FIND,   '0);                     // search of empty set
      send_beat(ust_pkg::OP_REMOVE, '1);                     // remove absent key
      send_beat(ust_pkg::OP_ADD,    '0);
      send_beat(ust_pkg::OP_ADD,    '1);
      send_beat(ust_pkg::OP_ADD,    64'h5555_5555_5555_5555);
      send_beat(ust_pkg::OP_ADD,    64'h8000_0000_0000_0000); // zero but top bit
      send_beat(ust_pkg::OP_ADD,    '0);                     // already held
      send_beat(ust_pkg::OP_FIND,   64'h0000_0000_0000_0001); // near miss
      send_beat(ust_pkg::OP_REMOVE, '0);                     // last key moves to slot 0
      send_beat(ust_pkg::OP_FIND,   64'h8000_0000_0000_0000);
      send_beat(ust_pkg::OP_REMOVE, '1);                     // middle slot
      send_beat(ust_pkg::OP_REMOVE, 64'h5555_5555_5555_5555); // last slot
      send_beat(ust_pkg::OP_COUNT,  64'hAAAA_AAAA_AAAA_AAAA); // key ignored

      // Directed, small capacity: full table, then capacity dropped below count.
      set_capacity(2);
      send_beat(ust_pkg::OP_ADD,    64'hAAAA_AAAA_AAAA_AAAA);
      send_beat(ust_pkg::OP_ADD,    64'hDEAD_BEEF_0000_FFFF); // refused, full
      send_beat(ust_pkg::OP_ADD,    64'h8000_0000_0000_0000); // held, not refused
      set_capacity(1);
      send_beat(ust_pkg::OP_FIND,   64'hAAAA_AAAA_AAAA_AAAA);
      send_beat(ust_pkg::OP_REMOVE, 64'h8000_0000_0000_0000);
      send_beat(ust_pkg::OP_ADD,    '0);                     // count == limit, refused
      send_beat(ust_pkg::OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA);
      send_beat(ust_pkg::OP_ADD,    '0);                     // fits again

      // Random phases: cap, pool, add%, remove%, send idle%, recv stall%, beats.
      // Order matters: fill to depth, overshoot depth, then shrink below count.
      run_phase(64,  80, 60, 15,  0,  0, 136);
      run_phase(127, 96, 40, 30, 73,  0, 136);
      run_phase(3,   96, 20, 55,  0, 73, 136);
      run_phase(0,   96, 30, 40, 36, 36, 136);
      run_phase(1,    8, 40, 30,  0,  0, 136);
      run_phase(40,  60, 50, 25, 73,  0, 136);
      run_phase($urandom_range(64, 1), 50, 40, 30, 0, 73, 136);
      run_phase(64,  96, 55, 20, 36, 36, 136);

      // All sent: wait out the responses, then keep the clock running to catch
      // any stray beat.
      drain();
      repeat (80) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
